// ----- rtl/core/mee_pkg.sv -----
// Shared widths, constants and the CORDIC step-angle function for the
// rotation matrix to Euler angle extractor. No dependencies.
package mee_pkg;

    localparam int ELEM_W       = 24;          // one matrix element, signed Q7.16
    localparam int ANG_W        = 25;          // one output angle
    localparam int SQ_W         = 48;          // square of one element
    localparam int RAD_W        = 64;          // square root radicand
    localparam int ROOT_W       = 32;          // square root result
    localparam int XY_W         = 57;          // signed atan2 argument
    localparam int NORM_W       = 64;          // magnitude word during normalization
    localparam int MAG_W        = 53;          // normalized magnitude
    localparam int CW           = 57;          // CORDIC x and y
    localparam int Z_W          = 34;          // CORDIC angle, 2^-24 degree
    localparam int NORM_STAGES  = 6;
    localparam int CORDIC_ITERATIONS_DEF = 20;

    localparam logic signed [Z_W-1:0] DEG90_FINE = 34'sd1509949440;
    localparam logic signed [Z_W-1:0] ROUND_HALF = 34'sd128;
    localparam logic signed [Z_W-1:0] ANG_LIMIT  = 34'sd11796480;
    localparam logic [63:0] RAD2DEG_2P40 = 64'd62997375797122;

    // Pipeline depth of one CORDIC lane: magnitude, normalize, quadrant fold,
    // the iterations and the rounding stage.
    function automatic int cordic_latency(input int iters);
        return iters + NORM_STAGES + 3;
    endfunction

    // Angle of step i in units of 2^-24 degree.
    function automatic logic signed [Z_W-1:0] step_angle(input int i);
        logic [63:0] v;
        v = '0;
        case (i)
            0:  v = 64'd754974720;
            1:  v = 64'd445687602;
            2:  v = 64'd235489088;
            3:  v = 64'd119537938;
            4:  v = 64'd60000934;
            5:  v = 64'd30029717;
            6:  v = 64'd15018523;
            7:  v = 64'd7509720;
            8:  v = 64'd3754917;
            9:  v = 64'd1877466;
            10: v = 64'd938734;
            11: v = 64'd469367;
            default: v = (RAD2DEG_2P40 + (64'd1 << (15 + i))) >> (16 + i);
        endcase
        return $signed(v[Z_W-1:0]);
    endfunction

endpackage

// ----- rtl/core/mee_isqrt.sv -----
// Pipelined floor square root, one result bit per stage.
// Depends on mee_pkg.
module mee_isqrt
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [mee_pkg::RAD_W-1:0]   radicand,
    output logic [mee_pkg::ROOT_W-1:0]  root
);

    localparam int RW  = mee_pkg::RAD_W;
    localparam int QW  = mee_pkg::ROOT_W;
    localparam int REM = mee_pkg::ROOT_W + 2;

    logic [RW-1:0]  rad_reg  [0:QW-1];
    logic [REM-1:0] rem_reg  [0:QW-1];
    logic [QW-1:0]  root_reg [0:QW-1];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            logic [RW-1:0]  rad_cur;
            logic [REM-1:0] rem_cur;
            logic [QW-1:0]  root_cur;
            logic [REM-1:0] rem_sh;
            logic [REM-1:0] trial;
            logic           fits;

            if (k == 0) begin : g_first
                assign rad_cur  = radicand;
                assign rem_cur  = '0;
                assign root_cur = '0;
            end
            else begin : g_next
                assign rad_cur  = rad_reg[k-1];
                assign rem_cur  = rem_reg[k-1];
                assign root_cur = root_reg[k-1];
            end

            // Bring down the next two radicand bits and try root*4+1.
            assign rem_sh = {rem_cur[REM-3:0], rad_cur[RW-1 -: 2]};
            assign trial  = {root_cur, 2'b01};
            assign fits   = (rem_sh >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[k]  <= {rad_cur[RW-3:0], 2'b00};
                    rem_reg[k]  <= fits ? (rem_sh - trial) : rem_sh;
                    root_reg[k] <= {root_cur[QW-2:0], fits};
                end
            end
        end
    endgenerate

    assign root = root_reg[QW-1];

endmodule

// ----- rtl/core/mee_cordic.sv -----
// One atan2 lane: magnitude normalization, quadrant fold and a pipelined
// vectoring CORDIC with rounding to 1/65536 degree. Depends on mee_pkg.
module mee_cordic
#(
    parameter int CORDIC_ITERATIONS = mee_pkg::CORDIC_ITERATIONS_DEF
)
(
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [mee_pkg::XY_W-1:0]   y_in,
    input  logic signed [mee_pkg::XY_W-1:0]   x_in,
    output logic signed [mee_pkg::ANG_W-1:0]  angle
);

    localparam int NW = mee_pkg::NORM_W;
    localparam int MW = mee_pkg::MAG_W;
    localparam int NS = mee_pkg::NORM_STAGES;
    localparam int CW = mee_pkg::CW;
    localparam int ZW = mee_pkg::Z_W;

    // Magnitudes and signs through the normalizer.
    logic [NW-1:0] ax_reg [0:NS];
    logic [NW-1:0] ay_reg [0:NS];
    logic          sx_reg [0:NS];
    logic          sy_reg [0:NS];

    logic signed [CW-1:0] cx_reg [0:CORDIC_ITERATIONS];
    logic signed [CW-1:0] cy_reg [0:CORDIC_ITERATIONS];
    logic signed [ZW-1:0] z_reg  [0:CORDIC_ITERATIONS];
    logic                 nul_reg [0:CORDIC_ITERATIONS];

    logic signed [mee_pkg::ANG_W-1:0] angle_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg[0] <= NW'(x_in[CW-1] ? -x_in : x_in);
            ay_reg[0] <= NW'(y_in[CW-1] ? -y_in : y_in);
            sx_reg[0] <= x_in[CW-1];
            sy_reg[0] <= y_in[CW-1];
        end
    end

    // Left shifts by 32, 16, ... 1 bring the larger magnitude to the top bit.
    genvar j;
    generate
        for (j = 0; j < NS; j++) begin : g_norm
            localparam int SH = 32 >> j;
            logic [NW-1:0] both;
            assign both = ax_reg[j] | ay_reg[j];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (both[NW-1 -: SH] == '0)
                    begin
                        ax_reg[j+1] <= ax_reg[j] << SH;
                        ay_reg[j+1] <= ay_reg[j] << SH;
                    end
                    else
                    begin
                        ax_reg[j+1] <= ax_reg[j];
                        ay_reg[j+1] <= ay_reg[j];
                    end
                    sx_reg[j+1] <= sx_reg[j];
                    sy_reg[j+1] <= sy_reg[j];
                end
            end
        end
    endgenerate

    // Keeping the top bits truncates the larger magnitude into [2^52, 2^53).
    logic [MW-1:0] axn;
    logic [MW-1:0] ayn;
    logic          x_neg;
    logic          y_neg;

    assign axn   = ax_reg[NS][NW-1 -: MW];
    assign ayn   = ay_reg[NS][NW-1 -: MW];
    assign x_neg = sx_reg[NS] && (axn != '0);
    assign y_neg = sy_reg[NS] && (ayn != '0);

    // A vector in the left half plane is first turned by 90 degrees.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nul_reg[0] <= (ax_reg[NS] == '0) && (ay_reg[NS] == '0);
            if (x_neg)
            begin
                cx_reg[0] <= $signed(CW'(ayn));
                if (!y_neg)
                begin
                    cy_reg[0] <= $signed(CW'(axn));
                    z_reg[0]  <= mee_pkg::DEG90_FINE;
                end
                else
                begin
                    cy_reg[0] <= -$signed(CW'(axn));
                    z_reg[0]  <= -mee_pkg::DEG90_FINE;
                end
            end
            else
            begin
                cx_reg[0] <= $signed(CW'(axn));
                cy_reg[0] <= y_neg ? -$signed(CW'(ayn)) : $signed(CW'(ayn));
                z_reg[0]  <= '0;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < CORDIC_ITERATIONS; i++) begin : g_iter
            localparam logic signed [ZW-1:0] STEP = mee_pkg::step_angle(i);
            logic signed [CW-1:0] dx;
            logic signed [CW-1:0] dy;
            assign dx = cy_reg[i] >>> i;
            assign dy = cx_reg[i] >>> i;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!cy_reg[i][CW-1])
                    begin
                        cx_reg[i+1] <= cx_reg[i] + dx;
                        cy_reg[i+1] <= cy_reg[i] - dy;
                        z_reg[i+1]  <= z_reg[i] + STEP;
                    end
                    else
                    begin
                        cx_reg[i+1] <= cx_reg[i] - dx;
                        cy_reg[i+1] <= cy_reg[i] + dy;
                        z_reg[i+1]  <= z_reg[i] - STEP;
                    end
                    nul_reg[i+1] <= nul_reg[i];
                end
            end
        end
    endgenerate

    logic signed [ZW-1:0] z_round;
    assign z_round = (z_reg[CORDIC_ITERATIONS] + mee_pkg::ROUND_HALF) >>> 8;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (nul_reg[CORDIC_ITERATIONS])
                angle_reg <= '0;
            else if (z_round > mee_pkg::ANG_LIMIT)
                angle_reg <= mee_pkg::ANG_W'(mee_pkg::ANG_LIMIT);
            else if (z_round < -mee_pkg::ANG_LIMIT)
                angle_reg <= mee_pkg::ANG_W'(-mee_pkg::ANG_LIMIT);
            else
                angle_reg <= z_round[mee_pkg::ANG_W-1:0];
        end
    end

    assign angle = angle_reg;

endmodule

// ----- rtl/core/matrix_euler_angle_extract.sv -----
// Top level of the rotation matrix to Euler angle extractor: squares, row
// lengths, three CORDIC lanes and the output merge. Depends on mee_pkg,
// mee_isqrt and mee_cordic.
//
// Usage:
//   While s_tready is high, the slave channel takes one request per cycle
//   carrying the nine elements of the upper-left 3x3 of a transform, signed
//   Q7.16. The master channel returns angle_x, angle_y and angle_z in
//   1/65536 degree, with zero_row in tuser set when a row was all zero
//   (all angles then read zero). The pipeline runs through a squares stage,
//   a sums stage, 32 square root stages, one product stage,
//   CORDIC_ITERATIONS + 9 CORDIC stages and one output register.
//   Without a stall, throughput is one matrix per cycle: every stage is a
//   pipeline register and the three angle lanes run side by side.
//   The whole pipeline advances together. When the receiver holds tready low
//   with a result waiting, s_tready drops and all stages hold their contents;
//   nothing is lost or repeated.
//   Reset clears all valid flags and the side data; other data is not reset.
module matrix_euler_angle_extract
#(
    parameter int CORDIC_ITERATIONS = mee_pkg::CORDIC_ITERATIONS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (24 bits each, from bit 0)
    input  logic [215:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // angle_x [24:0], angle_y [49:25], angle_z [74:50], zeros [79:75]
    output logic [79:0]  m_tdata,
    // zero_row [0]
    output logic [0:0]   m_tuser
);

    localparam int EW   = mee_pkg::ELEM_W;
    localparam int SW   = mee_pkg::SQ_W;
    localparam int XW   = mee_pkg::XY_W;
    localparam int AW   = mee_pkg::ANG_W;
    localparam int SQL  = mee_pkg::ROOT_W;
    localparam int CLAT = mee_pkg::cordic_latency(CORDIC_ITERATIONS);

    typedef struct packed {
        logic                 valid;
        logic                 zero;
        logic signed [EW-1:0] m00;
        logic signed [EW-1:0] m01;
        logic signed [EW-1:0] m02;
        logic signed [EW-1:0] m12;
        logic signed [EW-1:0] m22;
    } side_t;

    typedef struct packed {
        logic valid;
        logic zero;
    } flag_t;

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Stage 1: squares of all nine elements.
    logic                 v1_reg;
    logic signed [EW-1:0] m1_reg  [0:8];
    logic [SW-1:0]        sq1_reg [0:8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= s_tvalid;
    end

    genvar e;
    generate
        for (e = 0; e < 9; e++) begin : g_sq
            logic signed [EW-1:0] el;
            assign el = $signed(s_tdata[EW*e +: EW]);
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    m1_reg[e]  <= el;
                    sq1_reg[e] <= $unsigned(SW'(el) * SW'(el));
                end
            end
        end
    endgenerate

    // Stage 2: row sums and square root radicands.
    logic [SW-1:0] s0;
    logic [SW-1:0] s1;
    logic [SW-1:0] s2;
    logic [SW-1:0] h2;

    assign h2 = sq1_reg[0] + sq1_reg[1];
    assign s0 = h2 + sq1_reg[2];
    assign s1 = sq1_reg[3] + sq1_reg[4] + sq1_reg[5];
    assign s2 = sq1_reg[6] + sq1_reg[7] + sq1_reg[8];

    side_t                      side_reg [0:SQL];
    logic [mee_pkg::RAD_W-1:0]  rad1_reg;
    logic [mee_pkg::RAD_W-1:0]  rad2_reg;
    logic [mee_pkg::RAD_W-1:0]  radh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg[0] <= '0;
        else if (adv)
        begin
            side_reg[0].valid <= v1_reg;
            side_reg[0].zero  <= (s0 == '0) || (s1 == '0) || (s2 == '0);
            side_reg[0].m00   <= m1_reg[0];
            side_reg[0].m01   <= m1_reg[1];
            side_reg[0].m02   <= m1_reg[2];
            side_reg[0].m12   <= m1_reg[5];
            side_reg[0].m22   <= m1_reg[8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad1_reg <= {2'b00, s1, 14'd0};
            rad2_reg <= {2'b00, s2, 14'd0};
            radh_reg <= {h2, 16'd0};
        end
    end

    // Row lengths, 32 stages; the side data rides along.
    logic [SQL-1:0] l1;
    logic [SQL-1:0] l2;
    logic [SQL-1:0] hl;

    mee_isqrt u_sqrt_row1 (.clk(clk), .en(adv), .radicand(rad1_reg), .root(l1));
    mee_isqrt u_sqrt_row2 (.clk(clk), .en(adv), .radicand(rad2_reg), .root(l2));
    mee_isqrt u_sqrt_hyp  (.clk(clk), .en(adv), .radicand(radh_reg), .root(hl));

    genvar d;
    generate
        for (d = 0; d < SQL; d++) begin : g_side
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    side_reg[d+1] <= '0;
                else if (adv)
                    side_reg[d+1] <= side_reg[d];
            end
        end
    endgenerate

    // Product stage: atan2 arguments for the three lanes. Row scaling of
    // angle_x is folded in by cross multiplication with the other row length.
    side_t sd;
    assign sd = side_reg[SQL];

    logic signed [XW-1:0] yx_reg;
    logic signed [XW-1:0] xx_reg;
    logic signed [XW-1:0] yy_reg;
    logic signed [XW-1:0] xy_reg;
    logic signed [XW-1:0] yz_reg;
    logic signed [XW-1:0] xz_reg;
    flag_t                flag_reg [0:CLAT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            yx_reg <= XW'(sd.m12) * XW'($signed({1'b0, l2}));
            xx_reg <= XW'(sd.m22) * XW'($signed({1'b0, l1}));
            yy_reg <= -(XW'(sd.m02) <<< 8);
            xy_reg <= $signed(XW'(hl));
            yz_reg <= XW'(sd.m01);
            xz_reg <= XW'(sd.m00);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flag_reg[0] <= '0;
        else if (adv)
        begin
            flag_reg[0].valid <= sd.valid;
            flag_reg[0].zero  <= sd.zero;
        end
    end

    generate
        for (d = 0; d < CLAT; d++) begin : g_flag
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    flag_reg[d+1] <= '0;
                else if (adv)
                    flag_reg[d+1] <= flag_reg[d];
            end
        end
    endgenerate

    logic signed [AW-1:0] ang_x;
    logic signed [AW-1:0] ang_y;
    logic signed [AW-1:0] ang_z;

    mee_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_lane_x
    (
        .clk(clk), .en(adv), .y_in(yx_reg), .x_in(xx_reg), .angle(ang_x)
    );

    mee_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_lane_y
    (
        .clk(clk), .en(adv), .y_in(yy_reg), .x_in(xy_reg), .angle(ang_y)
    );

    mee_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_lane_z
    (
        .clk(clk), .en(adv), .y_in(yz_reg), .x_in(xz_reg), .angle(ang_z)
    );

    // Merge: a zero-length row overrides all three lanes.
    logic                 out_valid_reg;
    logic                 out_zero_reg;
    logic signed [AW-1:0] out_x_reg;
    logic signed [AW-1:0] out_y_reg;
    logic signed [AW-1:0] out_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= flag_reg[CLAT].valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_zero_reg <= flag_reg[CLAT].zero;
            out_x_reg    <= flag_reg[CLAT].zero ? '0 : ang_x;
            out_y_reg    <= flag_reg[CLAT].zero ? '0 : ang_y;
            out_z_reg    <= flag_reg[CLAT].zero ? '0 : ang_z;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_z_reg, out_y_reg, out_x_reg};
    assign m_tuser  = out_zero_reg;

endmodule
